/* hw/rtl/shdd_pkg.sv */
package shdd_pkg;

	// Unit operation select
	typedef enum logic {
		MODE_DIV,
		MODE_SQRT
	} sqdiv_mode_t;

	typedef struct packed {
		logic        start;
		sqdiv_mode_t mode;
		logic [5:0]  steps;
		logic [53:0] operand;
		logic [13:0] divisor;
	} sqdiv_ctl_t;

	typedef struct packed {
		logic        busy;
		logic [53:0] quot;
		logic [26:0] root;
	} sqdiv_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_SQX,
		ST_SQY,
		ST_MAG_GO,
		ST_MAG_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_MUL1,
		ST_MUL2,
		ST_OUT
	} shdd_state_t;

	localparam logic [5:0] MAG_STEPS  = 6'd13;
	localparam logic [5:0] DIV_STEPS  = 6'd54;
	localparam logic [5:0] RATE_STEPS = 6'd27;

	// atan(2^-i) in 2^-24 turn
	localparam logic [21:0] ATAN_TURN24 [16] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
		22'd166669,  22'd83416,   22'd41718,  22'd20860,
		22'd10430,   22'd5215,    22'd2608,   22'd1304,
		22'd652,     22'd326,     22'd163,    22'd81
	};

endpackage

/* hw/rtl/shdd_sqdiv.sv */
module shdd_sqdiv (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shdd_pkg::sqdiv_ctl_t   ctl,
	output shdd_pkg::sqdiv_sts_t   sts
);
	import shdd_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	sqdiv_mode_t mode_q;
	logic [53:0] s_q;
	logic [29:0] r_q;
	logic [26:0] root_q;
	logic [13:0] div_q;

	logic [29:0] r_sh;
	logic [29:0] trial;
	logic [29:0] r_dif;
	logic        take;

	// one restoring step: shift in operand bits, compare, subtract
	always_comb begin
		if (mode_q == MODE_DIV) begin
			r_sh  = {r_q[28:0], s_q[53]};
			trial = {16'd0, div_q};
		end else begin
			r_sh  = {r_q[27:0], s_q[53:52]};
			trial = {1'b0, root_q, 2'b01};
		end
		take  = (r_sh >= trial);
		r_dif = r_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= MODE_DIV;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ctl.steps;
			mode_q <= ctl.mode;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			s_q    <= ctl.operand;
			r_q    <= '0;
			root_q <= '0;
			div_q  <= ctl.divisor;
		end else if (busy_q) begin
			r_q <= take ? r_dif : r_sh;
			if (mode_q == MODE_DIV) begin
				s_q <= {s_q[52:0], take};
			end else begin
				s_q    <= {s_q[51:0], 2'b00};
				root_q <= {root_q[25:0], take};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.quot = s_q;
	assign sts.root = root_q;

endmodule

/* hw/rtl/shdd_cordic.sv */
module shdd_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [13:0] vec_x,
	input  logic signed [13:0] vec_y,
	output logic               busy,
	output logic [15:0]        angle
);
	import shdd_pkg::*;

	logic               busy_q;
	logic [3:0]         cnt_q;
	logic               zero_q;
	logic signed [24:0] x_q;
	logic signed [24:0] y_q;
	logic signed [24:0] ang_q;

	logic signed [24:0] x0;
	logic signed [24:0] y0;
	logic signed [24:0] xs;
	logic signed [24:0] ys;
	logic signed [24:0] step;
	logic signed [24:0] rnd;

	assign x0   = 25'($signed({vec_x, 8'd0}));
	assign y0   = 25'($signed({vec_y, 8'd0}));
	assign xs   = x_q >>> cnt_q;
	assign ys   = y_q >>> cnt_q;
	assign step = $signed({3'd0, ATAN_TURN24[cnt_q]});
	assign rnd  = ang_q + 25'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (vec_x == 14'sd0) && (vec_y == 14'sd0);
			// fold the left half plane over by half a turn
			if (vec_x[13]) begin
				x_q   <= -x0;
				y_q   <= -y0;
				ang_q <= 25'sd8388608;
			end else begin
				x_q   <= x0;
				y_q   <= y0;
				ang_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 25'sd0) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				ang_q <= ang_q + step;
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				ang_q <= ang_q - step;
			end
		end
	end

	assign busy  = busy_q;
	assign angle = zero_q ? 16'd0 : rnd[23:8];

endmodule

/* hw/rtl/spin_heading_drift_drive.sv */
// Each accepted word runs through 13 + 54 + 27 single-bit steps of the shared
// divide/square-root unit plus sequencing states before its result word is
// valid. The input is ready only while the sequencer is idle, so a new word
// is taken only after the last result is loaded. The output register holds a
// result until taken. Reset clears the filter and heading, radius to 250.
module spin_heading_drift_drive #(
	parameter int HEADING_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration: sensor radius
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [13:0]        cfg_data,
	// input words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [11:0]        stick_x_pulse,
	input  logic [11:0]        stick_y_pulse,
	input  logic [11:0]        throttle_pulse,
	input  logic [15:0]        tick_length,
	input  logic signed [15:0] radial_accel,
	// result words
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [13:0] motor_a_drive,
	output logic signed [13:0] motor_b_drive,
	output logic [15:0]        heading_now
);
	import shdd_pkg::*;

	localparam int HB = HEADING_BITS;

	shdd_state_t state_q, state_d;

	// configuration and persistent state
	logic [13:0]        radius_q;
	logic signed [31:0] filtered_q;
	logic [HB-1:0]      heading_q;

	// captured word
	logic [11:0]        px_q, py_q, pt_q;
	logic [15:0]        tick_q;
	logic signed [15:0] acc_q;

	// working registers
	logic [13:0]        qx_q, qy_q;
	logic [12:0]        thr_q;
	logic signed [63:0] p1_q;
	logic [25:0]        sq_q;
	logic [52:0]        num_q;
	logic [12:0]        mag_q;
	logic [26:0]        w_q;
	logic [42:0]        wt_q;

	// output register
	logic               out_valid_q;
	logic signed [13:0] ma_q, mb_q;
	logic [15:0]        hout_q;

	sqdiv_ctl_t ctl;
	sqdiv_sts_t sts;
	logic       cordic_start;
	logic       cordic_busy;
	logic [15:0] dir;
	logic       out_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= 14'd250;
		else if (cfg_valid)
			radius_q <= cfg_data;
	end

	// ---- stick and throttle mapping ----
	// stick value = u/1020 with u = 2p - offset; Q12 result is
	// floor((2048u + 255)/510), biased by 510*4200 to keep the dividend
	// positive and divided by a reciprocal multiply.
	logic signed [13:0] ux, uy;
	logic               ux_ok, uy_ok;
	logic signed [24:0] nx_full, ny_full;
	logic [46:0]        px_prod, py_prod;
	logic signed [13:0] sx, sy;

	assign ux = $signed({1'b0, px_q, 1'b0}) - 14'sd3008;
	assign uy = $signed({1'b0, py_q, 1'b0}) - 14'sd3000;
	assign ux_ok = (ux >= -14'sd1040) && (ux <= 14'sd1040);
	assign uy_ok = (uy >= -14'sd1040) && (uy <= 14'sd1040);
	assign nx_full = $signed({ux, 11'd0}) + 25'sd2142255;
	assign ny_full = $signed({uy, 11'd0}) + 25'sd2142255;
	assign px_prod = 47'(nx_full[22:0]) * 47'(24'd8421505);
	assign py_prod = 47'(ny_full[22:0]) * 47'(24'd8421505);
	assign sx = ux_ok ? 14'($signed({1'b0, qx_q}) - 15'sd4200) : 14'sd0;
	assign sy = uy_ok ? 14'($signed({1'b0, qy_q}) - 15'sd4200) : 14'sd0;

	// throttle = floor((4096t + 507)/1014), zero below 0.05, held at 1
	logic signed [12:0] tt;
	logic signed [24:0] nt_full;
	logic [44:0]        pt_prod;

	assign tt      = $signed({1'b0, pt_q}) - 13'sd1000;
	assign nt_full = $signed({tt, 12'd0}) + 25'sd507;
	assign pt_prod = 45'(nt_full[21:0]) * 45'(23'd4235668);

	// ---- leaky filter: 0.9 old + 0.01 new, rounded ----
	logic signed [64:0] p1_full;
	logic signed [42:0] p2;
	logic signed [63:0] p2s;
	logic signed [63:0] fsum;

	assign p1_full = $signed(filtered_q) * $signed({1'b0, 32'd3865470566});
	assign p2      = $signed(acc_q) * $signed({1'b0, 26'd42949673});
	assign p2s     = 64'($signed({p2, 16'd0}));
	assign fsum    = p1_q + p2s + 64'sd2147483648;

	logic signed [27:0] sqx, sqy;
	assign sqx = sx * sx;
	assign sqy = sy * sy;

	// ---- heading advance ----
	logic [60:0]   hprod;
	logic [HB-1:0] delta;
	logic [15:0]   h16;
	logic [15:0]   diff;
	logic          facing;
	logic [11:0]   half;
	logic signed [13:0] lo_drv, hi_drv;

	assign hprod = wt_q * 61'(18'd174993);
	assign delta = hprod[55 -: HB];

	generate
		if (HB >= 16) begin : g_h16_wide
			assign h16 = heading_q[HB-1 -: 16];
		end else begin : g_h16_narrow
			assign h16 = {heading_q, {(16 - HB){1'b0}}};
		end
	endgenerate

	// drive split: swap sides when the stick points away from the heading
	assign diff   = dir - h16;
	assign facing = (diff[15] == diff[14]);
	assign half   = mag_q[12:1];
	assign lo_drv = $signed({1'b0, thr_q}) - $signed({2'b00, half});
	assign hi_drv = $signed({1'b0, thr_q}) + $signed({2'b00, half});

	// ---- shared units ----
	shdd_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	shdd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.vec_x  (sy),
		.vec_y  (sx),
		.busy   (cordic_busy),
		.angle  (dir)
	);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cordic_start = 1'b0;
		out_load     = 1'b0;
		ctl.start    = 1'b0;
		ctl.mode     = MODE_SQRT;
		ctl.steps    = MAG_STEPS;
		ctl.operand  = {sq_q, 28'd0};
		ctl.divisor  = (radius_q == 14'd0) ? 14'd1 : radius_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_MAP;
			end
			ST_MAP: state_d = ST_SQX;
			ST_SQX: begin
				cordic_start = 1'b1;
				state_d      = ST_SQY;
			end
			ST_SQY: state_d = ST_MAG_GO;
			ST_MAG_GO: begin
				// magnitude: root of the top 26 bits
				ctl.start = 1'b1;
				state_d   = ST_MAG_WAIT;
			end
			ST_MAG_WAIT: begin
				if (!sts.busy)
					state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				ctl.start   = 1'b1;
				ctl.mode    = MODE_DIV;
				ctl.steps   = DIV_STEPS;
				ctl.operand = {1'b0, num_q};
				state_d     = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!sts.busy)
					state_d = ST_RT_GO;
			end
			ST_RT_GO: begin
				// spin rate: root of the quotient left in the unit
				ctl.start   = 1'b1;
				ctl.steps   = RATE_STEPS;
				ctl.operand = sts.quot;
				state_d     = ST_RT_WAIT;
			end
			ST_RT_WAIT: begin
				if (!sts.busy)
					state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_OUT;
			ST_OUT: begin
				if (!cordic_busy && (!out_valid_q || out_ready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q <= '0;
			heading_q  <= '0;
		end else begin
			if (state_q == ST_SQX)
				filtered_q <= fsum[63:32];
			if (state_q == ST_MUL2)
				heading_q <= heading_q + delta;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					px_q   <= stick_x_pulse;
					py_q   <= stick_y_pulse;
					pt_q   <= throttle_pulse;
					tick_q <= tick_length;
					acc_q  <= radial_accel;
				end
			end
			ST_MAP: begin
				qx_q <= px_prod[45:32];
				qy_q <= py_prod[45:32];
				if (tt <= 13'sd50)
					thr_q <= '0;
				else if (tt > 13'sd1014)
					thr_q <= 13'd4096;
				else
					thr_q <= pt_prod[44:32];
				p1_q <= p1_full[63:0];
			end
			ST_SQX: sq_q <= sqx[25:0];
			ST_SQY: begin
				sq_q  <= sq_q + sqy[25:0];
				// no spin for a negative or zero filtered value
				num_q <= filtered_q[31] ? 53'd0
					: 53'(filtered_q[30:0]) * 53'(22'd2560000);
			end
			ST_MAG_WAIT: begin
				if (!sts.busy)
					mag_q <= (sts.root[12:0] > 13'd4096) ? 13'd4096 : sts.root[12:0];
			end
			ST_RT_WAIT: begin
				if (!sts.busy)
					w_q <= sts.root;
			end
			ST_MUL1: wt_q <= 43'(w_q) * 43'(tick_q);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ma_q   <= facing ? lo_drv : hi_drv;
			mb_q   <= facing ? hi_drv : lo_drv;
			hout_q <= h16;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_a_drive = ma_q;
	assign motor_b_drive = mb_q;
	assign heading_now   = hout_q;

endmodule
